// File: rtl/adpe_pkg.sv
// Shared types and constants for the data-processing execute block.
// No dependencies; imported by the shifter, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package adpe_pkg;

    localparam int unsigned XLEN        = 32;
    localparam int unsigned REG_COUNT   = 16;
    localparam int unsigned REG_IDX_W   = 4;

    // Stream word layout on the input side (action travels in tuser).
    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned IN_INSTR_LO = 0;
    localparam int unsigned IN_LIDX_LO  = 32;
    localparam int unsigned IN_LVAL_LO  = 36;

    // Stream word layout on the output side.
    localparam int unsigned OUT_TDATA_W   = 48;
    localparam int unsigned OUT_IDX_LO    = 0;
    localparam int unsigned OUT_VAL_LO    = 4;
    localparam int unsigned OUT_WR_BIT    = 36;
    localparam int unsigned OUT_N_BIT     = 37;
    localparam int unsigned OUT_Z_BIT     = 38;
    localparam int unsigned OUT_C_BIT     = 39;
    localparam int unsigned OUT_UNSUP_BIT = 40;

    localparam logic ACT_EXECUTE = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic [XLEN-1:0] value;
        logic            carry;
    } t_shift_res;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
    } t_flags;

endpackage

`default_nettype wire

// File: rtl/adpe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; the top level uses one copy per register-file read port.
`timescale 1ns / 1ps
`default_nettype none

module adpe_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/adpe_shifter.sv
// Operand2 barrel shifter: rotated immediate or shifted register with carry-out.
// Depends on adpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adpe_shifter
    import adpe_pkg::*;
(
    input  wire logic            i_imm_sel,   // I bit of the instruction
    input  wire logic [11:0]     i_op2,       // operand2 field
    input  wire logic [XLEN-1:0] i_rm,
    input  wire logic [7:0]      i_rs_byte,
    input  wire logic            i_cin,
    output t_shift_res           o_res
);

    logic [1:0]        sh_type;
    logic [4:0]        const_amt;
    logic [7:0]        amt;
    logic [4:0]        amt_lo;
    logic [XLEN:0]     lsl_ext;
    logic [XLEN:0]     lsr_ext;
    logic signed [XLEN:0] asr_src;
    logic signed [XLEN:0] asr_ext;
    logic [2*XLEN-1:0] ror_ext;
    logic [XLEN-1:0]   imm_ext;
    logic [2*XLEN-1:0] imm_rot;
    logic [4:0]        imm_amt;

    assign sh_type   = i_op2[6:5];
    assign const_amt = i_op2[11:7];
    assign amt_lo    = amt[4:0];
    assign lsl_ext   = {1'b0, i_rm} << amt_lo;
    assign lsr_ext   = {i_rm, 1'b0} >> amt_lo;
    assign asr_src   = {i_rm, 1'b0};
    assign asr_ext   = asr_src >>> amt_lo;
    assign ror_ext   = {i_rm, i_rm} >> amt_lo;
    assign imm_ext   = {24'd0, i_op2[7:0]};
    assign imm_amt   = {i_op2[11:8], 1'b0};
    assign imm_rot   = {imm_ext, imm_ext} >> imm_amt;

    // A constant amount of zero means a shift by 32 for lsr and asr.
    always_comb begin
        if (i_op2[4]) begin
            amt = i_rs_byte;
        end else if (const_amt == 5'd0 && (sh_type == SH_LSR || sh_type == SH_ASR)) begin
            amt = 8'd32;
        end else begin
            amt = {3'd0, const_amt};
        end
    end

    always_comb begin
        o_res = '{value: i_rm, carry: i_cin};
        if (i_imm_sel) begin
            if (imm_amt != 5'd0) begin
                o_res.value = imm_rot[XLEN-1:0];
                o_res.carry = imm_rot[XLEN-1];
            end else begin
                o_res.value = imm_ext;
            end
        end else if (!i_op2[4] && const_amt == 5'd0 && sh_type == SH_ROR) begin
            // Rotate right extended through the carry.
            o_res.value = {i_cin, i_rm[XLEN-1:1]};
            o_res.carry = i_rm[0];
        end else if (amt != 8'd0) begin
            case (sh_type)
                SH_LSL: begin
                    if (amt < 8'd32) begin
                        o_res.value = lsl_ext[XLEN-1:0];
                        o_res.carry = lsl_ext[XLEN];
                    end else begin
                        o_res.value = '0;
                        o_res.carry = (amt == 8'd32) ? i_rm[0] : 1'b0;
                    end
                end
                SH_LSR: begin
                    if (amt < 8'd32) begin
                        o_res.value = lsr_ext[XLEN:1];
                        o_res.carry = lsr_ext[0];
                    end else begin
                        o_res.value = '0;
                        o_res.carry = (amt == 8'd32) ? i_rm[XLEN-1] : 1'b0;
                    end
                end
                SH_ASR: begin
                    if (amt < 8'd32) begin
                        o_res.value = asr_ext[XLEN:1];
                        o_res.carry = asr_ext[0];
                    end else begin
                        o_res.value = {XLEN{i_rm[XLEN-1]}};
                        o_res.carry = i_rm[XLEN-1];
                    end
                end
                default: begin
                    // A multiple of 32 leaves the value and copies bit 31 to carry.
                    o_res.value = ror_ext[XLEN-1:0];
                    o_res.carry = ror_ext[XLEN-1];
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/arm_data_processing_execute_top.sv
// Top level of the data-processing execute block: register file, ALU, flags.
// Depends on adpe_pkg, adpe_ram and adpe_shifter.
//
// Usage:
//   Input stream (s_axis): one word per item. tuser is the action (0 execute
//   the instruction, 1 preset register load_index with load_value).
//   Output stream (m_axis): one result word per input word, in order, giving
//   Rd, the computed value, whether the register file was written, the N/Z/C
//   flags after the item and an unsupported-opcode flag.
//   Throughput is one word per cycle while the receiver does not stall: the
//   register file is read at accept into three RAM copies (Rn, Rm, Rs ports),
//   the ALU works in the following cycle and writes back as the result enters
//   the output register; a one-entry bypass covers the write that lands in
//   the same cycle as the next read.
//   Reset clears the register file (through per-entry valid bits), the flags
//   and both pipeline stages; input ready is high in the first cycle after.
//   When the receiver stalls, the output word holds, one more word waits in the
//   execute stage and input ready drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module arm_data_processing_execute_top
    import adpe_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: instruction[31:0], load_index[35:32], load_value[67:36], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: action
    input  wire logic                   i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: dest_index[3:0], dest_value[35:4], dest_written[36], flag_neg[37],
    // flag_zero[38], flag_carry[39], unsupported[40], zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    logic s_accept;
    logic s1_adv;

    logic [XLEN-1:0] in_instr;
    assign in_instr = i_s_axis_tdata[IN_INSTR_LO +: XLEN];

    // Execute stage.
    logic                 r_s1_valid;
    logic                 r_s1_action;
    logic [XLEN-1:0]      r_s1_instr;
    logic [REG_IDX_W-1:0] r_s1_lidx;
    logic [XLEN-1:0]      r_s1_lval;
    logic                 r_s1_rn_ok;
    logic                 r_s1_rm_ok;
    logic                 r_s1_rs_ok;

    // Register file bookkeeping and status.
    logic [REG_COUNT-1:0] r_reg_ok;
    logic                 r_wb_valid;
    logic [REG_IDX_W-1:0] r_wb_idx;
    logic [XLEN-1:0]      r_wb_data;
    t_flags               r_flags;
    t_flags               n_flags;

    // Output register.
    logic                 r_out_valid;
    logic [REG_IDX_W-1:0] r_out_idx;
    logic [XLEN-1:0]      r_out_value;
    logic                 r_out_written;
    t_flags               r_out_flags;
    logic                 r_out_unsup;

    logic [XLEN-1:0] ram_rn;
    logic [XLEN-1:0] ram_rm;
    logic [XLEN-1:0] ram_rs;
    logic [XLEN-1:0] rn_val;
    logic [XLEN-1:0] rm_val;
    logic [XLEN-1:0] rs_val;

    logic [REG_IDX_W-1:0] s1_rn;
    logic [REG_IDX_W-1:0] s1_rm;
    logic [REG_IDX_W-1:0] s1_rs;
    logic [REG_IDX_W-1:0] s1_rd;
    logic [3:0]           s1_op;

    t_shift_res           op2;
    logic [XLEN-1:0]      add_a;
    logic [XLEN-1:0]      add_b;
    logic                 add_ci;
    logic [XLEN:0]        sum;

    logic [REG_IDX_W-1:0] n_idx;
    logic [XLEN-1:0]      n_value;
    logic                 n_written;
    logic                 n_unsup;
    logic                 n_carry;

    assign s1_adv          = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign s1_rn = r_s1_instr[19:16];
    assign s1_rm = r_s1_instr[3:0];
    assign s1_rs = r_s1_instr[11:8];
    assign s1_rd = r_s1_instr[15:12];
    assign s1_op = r_s1_instr[24:21];

    // Three copies of the register file give three read ports.
    adpe_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_rn (
        .i_clk   (i_clk),
        .i_we    (s1_adv && n_written),
        .i_waddr (n_idx),
        .i_wdata (n_value),
        .i_re    (s_accept),
        .i_raddr (in_instr[19:16]),
        .o_rdata (ram_rn)
    );

    adpe_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_rm (
        .i_clk   (i_clk),
        .i_we    (s1_adv && n_written),
        .i_waddr (n_idx),
        .i_wdata (n_value),
        .i_re    (s_accept),
        .i_raddr (in_instr[3:0]),
        .o_rdata (ram_rm)
    );

    adpe_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_rs (
        .i_clk   (i_clk),
        .i_we    (s1_adv && n_written),
        .i_waddr (n_idx),
        .i_wdata (n_value),
        .i_re    (s_accept),
        .i_raddr (in_instr[11:8]),
        .o_rdata (ram_rs)
    );

    // The bypass always holds the newest write, so a match is never stale.
    always_comb begin
        rn_val = r_s1_rn_ok ? ram_rn : '0;
        rm_val = r_s1_rm_ok ? ram_rm : '0;
        rs_val = r_s1_rs_ok ? ram_rs : '0;
        if (r_wb_valid && r_wb_idx == s1_rn) begin
            rn_val = r_wb_data;
        end
        if (r_wb_valid && r_wb_idx == s1_rm) begin
            rm_val = r_wb_data;
        end
        if (r_wb_valid && r_wb_idx == s1_rs) begin
            rs_val = r_wb_data;
        end
    end

    adpe_shifter u_shifter (
        .i_imm_sel (r_s1_instr[25]),
        .i_op2     (r_s1_instr[11:0]),
        .i_rm      (rm_val),
        .i_rs_byte (rs_val[7:0]),
        .i_cin     (r_flags.c),
        .o_res     (op2)
    );

    // One adder serves add, sub, rsb and cmp; carry out means no borrow.
    always_comb begin
        add_a  = rn_val;
        add_b  = op2.value;
        add_ci = 1'b0;
        case (s1_op) inside
            OP_SUB, OP_CMP: begin
                add_b  = ~op2.value;
                add_ci = 1'b1;
            end
            OP_RSB: begin
                add_a  = op2.value;
                add_b  = ~rn_val;
                add_ci = 1'b1;
            end
            default: begin
                add_a  = rn_val;
                add_b  = op2.value;
                add_ci = 1'b0;
            end
        endcase
    end

    assign sum = {1'b0, add_a} + {1'b0, add_b} + {{XLEN{1'b0}}, add_ci};

    always_comb begin
        n_idx     = s1_rd;
        n_value   = '0;
        n_written = 1'b0;
        n_unsup   = 1'b0;
        n_carry   = op2.carry;
        unique case (s1_op) inside
            OP_AND: begin
                n_value   = rn_val & op2.value;
                n_written = 1'b1;
            end
            OP_EOR: begin
                n_value   = rn_val ^ op2.value;
                n_written = 1'b1;
            end
            OP_SUB, OP_RSB, OP_ADD: begin
                n_value   = sum[XLEN-1:0];
                n_carry   = sum[XLEN];
                n_written = 1'b1;
            end
            OP_TST: n_value = rn_val & op2.value;
            OP_TEQ: n_value = rn_val ^ op2.value;
            OP_CMP: begin
                n_value = sum[XLEN-1:0];
                n_carry = sum[XLEN];
            end
            OP_ORR: begin
                n_value   = rn_val | op2.value;
                n_written = 1'b1;
            end
            OP_MOV: begin
                n_value   = op2.value;
                n_written = 1'b1;
            end
            default: n_unsup = 1'b1;
        endcase

        n_flags = r_flags;
        if (r_s1_action == ACT_LOAD) begin
            n_idx     = r_s1_lidx;
            n_value   = r_s1_lval;
            n_written = 1'b1;
            n_unsup   = 1'b0;
        end else if (!n_unsup && r_s1_instr[20]) begin
            n_flags.n = n_value[XLEN-1];
            n_flags.z = (n_value == '0);
            n_flags.c = n_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_reg_ok    <= '0;
            r_wb_valid  <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
                if (n_written) begin
                    r_reg_ok[n_idx] <= 1'b1;
                    r_wb_valid      <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_action <= i_s_axis_tuser;
            r_s1_instr  <= in_instr;
            r_s1_lidx   <= i_s_axis_tdata[IN_LIDX_LO +: REG_IDX_W];
            r_s1_lval   <= i_s_axis_tdata[IN_LVAL_LO +: XLEN];
            r_s1_rn_ok  <= r_reg_ok[in_instr[19:16]];
            r_s1_rm_ok  <= r_reg_ok[in_instr[3:0]];
            r_s1_rs_ok  <= r_reg_ok[in_instr[11:8]];
        end
        if (s1_adv) begin
            r_out_idx     <= n_idx;
            r_out_value   <= n_value;
            r_out_written <= n_written;
            r_out_flags   <= n_flags;
            r_out_unsup   <= n_unsup;
            if (n_written) begin
                r_wb_idx  <= n_idx;
                r_wb_data <= n_value;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata                            = '0;
        o_m_axis_tdata[OUT_IDX_LO +: REG_IDX_W]   = r_out_idx;
        o_m_axis_tdata[OUT_VAL_LO +: XLEN]        = r_out_value;
        o_m_axis_tdata[OUT_WR_BIT]                = r_out_written;
        o_m_axis_tdata[OUT_N_BIT]                 = r_out_flags.n;
        o_m_axis_tdata[OUT_Z_BIT]                 = r_out_flags.z;
        o_m_axis_tdata[OUT_C_BIT]                 = r_out_flags.c;
        o_m_axis_tdata[OUT_UNSUP_BIT]             = r_out_unsup;
    end

endmodule

`default_nettype wire

// File: rtl/adpe_checker.sv
// Port-level assertions for the execute block, bound to its top level.
// Depends on adpe_pkg and arm_data_processing_execute_top.
`timescale 1ns / 1ps
`default_nettype none

module adpe_checker
    import adpe_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    // Reset leaves no result word pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Input is refused only while a word waits at a stalled output.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without an output stall");

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output word changed while stalled");

    // An unsupported opcode writes nothing and reports a zero value.
    a_unsup_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[OUT_UNSUP_BIT]) |->
            (!o_m_axis_tdata[OUT_WR_BIT] && o_m_axis_tdata[OUT_VAL_LO +: XLEN] == '0))
        else $error("unsupported opcode produced a write or value");

endmodule

bind arm_data_processing_execute_top adpe_checker u_adpe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
